[hw/rtl/itda_pkg.sv]
// Shared constants and types of the integer to decimal ASCII printer.
package itda_pkg;

    localparam int DATA_BITS_DEF = 64;
    localparam int VALUE_W       = 64;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDE   = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic signed_mode;
        logic wide_mode;
    } t_mode;

endpackage

[hw/rtl/itda_front.sv]
// Front end: masks the input word to the active width and forms sign and magnitude.
module itda_front #(
    parameter int DATA_BITS = itda_pkg::DATA_BITS_DEF
) (
    input  logic [itda_pkg::VALUE_W-1:0] i_value_bits,
    input  itda_pkg::t_mode              i_mode,
    output logic                         o_neg,
    output logic [DATA_BITS-1:0]         o_mag
);
    import itda_pkg::*;

    localparam int W_NARROW = (DATA_BITS > 32) ? 32 : DATA_BITS;
    localparam logic [DATA_BITS-1:0] MASK_NARROW =
        {DATA_BITS{1'b1}} >> (DATA_BITS - W_NARROW);

    logic [DATA_BITS-1:0] v_mask;
    logic [DATA_BITS-1:0] v_word;
    logic                 v_sign;

    always_comb begin
        v_mask = i_mode.wide_mode ? {DATA_BITS{1'b1}} : MASK_NARROW;
        v_word = i_value_bits[DATA_BITS-1:0] & v_mask;
        v_sign = i_mode.wide_mode ? v_word[DATA_BITS-1] : v_word[W_NARROW-1];
        o_neg  = i_mode.signed_mode & v_sign;
        o_mag  = o_neg ? ((~v_word + {{(DATA_BITS-1){1'b0}}, 1'b1}) & v_mask) : v_word;
    end

endmodule

[hw/rtl/itda_queue.sv]
// Two-entry queue that holds classified items between the front and back ends.
module itda_queue #(
    parameter int WIDTH = itda_pkg::DATA_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import itda_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[hw/rtl/itda_back.sv]
// Back end: binary to BCD by shift and add three, then one character per cycle while the output is not stalled.
module itda_back #(
    parameter int DATA_BITS = itda_pkg::DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  logic                        i_neg,
    input  logic [DATA_BITS-1:0]        i_mag,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [itda_pkg::CHAR_W-1:0] o_ascii_char,
    output logic                        o_last_char
);
    import itda_pkg::*;

    localparam int NDIG   = (DATA_BITS * 1233) / 4096 + 1;
    localparam int BW     = NDIG * 4;
    localparam int CNT_W  = $clog2(DATA_BITS);
    localparam int LEFT_W = $clog2(NDIG + 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DATA_BITS - 1);
    localparam logic [LEFT_W-1:0] LEFT_FULL = LEFT_W'(NDIG);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CONV   = 5'b00010,
        ST_SKIP   = 5'b00100,
        ST_SIGN   = 5'b01000,
        ST_DIGITS = 5'b10000
    } t_state;

    t_state               r_state,    n_state;
    logic [CNT_W-1:0]     r_cnt,      n_cnt;
    logic [LEFT_W-1:0]    r_left,     n_left;
    logic                 r_neg,      n_neg;
    logic [DATA_BITS-1:0] r_bin,      n_bin;
    logic [BW-1:0]        r_bcd,      n_bcd;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [BW-1:0] v_adj;
    logic [3:0]    v_nib;
    logic [3:0]    v_top;
    logic          v_load;

    assign o_out_valid  = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last_char  = r_out_last;
    assign o_pop        = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        v_nib = 4'd0;
        for (int k = 0; k < NDIG; k++) begin
            v_nib = r_bcd[k*4 +: 4];
            v_adj[k*4 +: 4] = (v_nib >= 4'd5) ? (v_nib + 4'd3) : v_nib;
        end
    end

    always_comb begin
        v_top       = r_bcd[BW-1 -: 4];
        v_load      = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_bin   = i_mag;
                    n_neg   = i_neg;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {v_adj[BW-2:0], r_bin[DATA_BITS-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_left  = LEFT_FULL;
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((v_top == 4'd0) && (r_left != LEFT_ONE)) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - LEFT_ONE;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (v_load) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (v_load) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO + {4'd0, v_top};
                    n_out_last  = (r_left == LEFT_ONE);
                    n_bcd       = r_bcd << 4;
                    n_left      = r_left - LEFT_ONE;
                    if (r_left == LEFT_ONE) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_neg      <= n_neg;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

[hw/rtl/int_to_decimal_ascii.sv]
// The back end converts one bit per cycle by shift and add three, then skips leading zero
// digit positions and sends an optional minus sign and the digits. It takes no new item
// from the queue until it is through with the last one.
// The two-entry queue lets the front end take up to two items while the back end works.
// Synchronous active-low reset empties the queue and output register and sets both
// mode registers to 1 (signed, full width).
module int_to_decimal_ascii #(
    parameter int DATA_BITS = itda_pkg::DATA_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itda_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [itda_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [itda_pkg::VALUE_W-1:0]    i_value_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [itda_pkg::CHAR_W-1:0]     o_ascii_char,
    output logic                            o_last_char
);
    import itda_pkg::*;

    t_mode                r_mode;
    logic                 w_neg;
    logic [DATA_BITS-1:0] w_mag;
    logic                 w_full;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_job_valid;
    logic [DATA_BITS:0]   w_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_full;
    assign w_push      = i_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '{signed_mode: 1'b1, wide_mode: 1'b1};
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_SIGNED) begin
                r_mode.signed_mode <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_IDX_WIDE) begin
                r_mode.wide_mode <= i_cfg_data[0];
            end
        end
    end

    itda_front #(.DATA_BITS(DATA_BITS)) u_front (
        .i_value_bits (i_value_bits),
        .i_mode       (r_mode),
        .o_neg        (w_neg),
        .o_mag        (w_mag)
    );

    itda_queue #(.WIDTH(DATA_BITS + 1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_neg, w_mag}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_job)
    );

    itda_back #(.DATA_BITS(DATA_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_neg        (w_job[DATA_BITS]),
        .i_mag        (w_job[DATA_BITS-1:0]),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule
